>>> src/bmp_pkg.sv
// Shared types and constants for the BMP 24-bit to RGB565 stream decoder.
package bmp_pkg;

	// Decoder phases.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_PIXEL,
		PH_DONE
	} phase_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [16:0] TRANSPARENT_OFF = 17'h1FFFF;
	localparam logic [14:0] SCREEN_W_RST    = 15'd320;
	localparam logic [14:0] SCREEN_H_RST    = 15'd240;

	// File format constants.
	localparam logic [15:0] BMP_SIGNATURE  = 16'h4D42;
	localparam logic [15:0] BMP_DEPTH_24   = 16'd24;
	localparam logic [31:0] CORE_HDR_BYTES = 32'd12;
	localparam logic [31:0] HDR_END_SHORT  = 32'd30;
	localparam logic [31:0] HDR_END_LONG   = 32'd54;

	// Byte positions of the header fields.
	localparam logic [5:0] POS_SIG_LO   = 6'd0;
	localparam logic [5:0] POS_SIG_HI   = 6'd1;
	localparam logic [5:0] POS_OFFSET   = 6'd10;
	localparam logic [5:0] POS_HDR_SIZE = 6'd14;
	localparam logic [5:0] POS_WIDTH    = 6'd18;
	localparam logic [5:0] POS_HEIGHT   = 6'd22;
	localparam logic [5:0] POS_PLANES   = 6'd26;
	localparam logic [5:0] POS_DEPTH    = 6'd28;
	localparam logic [5:0] POS_COMPRESS = 6'd30;
	localparam logic [5:0] POS_HDR_LAST = 6'd53;

	// Status codes.
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_FORMAT = 1'b1;

	// Configuration as seen by the decoder core.
	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [16:0] transparent_color;
		logic [14:0] screen_width;
		logic [14:0] screen_height;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic        draw_pixel;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic [15:0] pixel_color;
		logic        done_res;
		logic        status;
	} res_t;

endpackage

>>> src/bmp24_to_rgb565_stream_decoder.sv
// Top level of the BMP 24-bit to RGB565 stream decoder.
//
// The s_ channel carries a BMP file one byte per transfer in file order;
// s_tuser marks the first byte of a new file and restarts the parser.
// The m_ channel carries result items: a pixel to draw (m_tuser[0]) with its
// screen coordinates and RGB565 colour, and m_tlast on the last result of an
// image, with m_tuser[1] giving the status (0 success, 1 unsupported format).
// Header bytes, skipped bytes, padding and transparent pixels give no result.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// Each byte passes an input register and the parser into the result
// register. One byte is accepted every cycle while the result register is
// free or being taken; the parser handles one byte per step.
// When the receiver stalls, the result register holds and the input register
// fills, after which s_tready drops until the result is taken.
// Reset clears both stages, puts the parser into its idle phase (bytes are
// ignored until a start byte) and loads the register defaults.
module bmp24_to_rgb565_stream_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] file_byte
	input  logic                               s_tuser,   // [0] start_of_file
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [47:0]                        m_tdata,   // [15:0] pixel_x, [31:16] pixel_y,
	                                                      // [47:32] pixel_color
	output logic [1:0]                         m_tuser,   // [0] draw_pixel, [1] status
	output logic                               m_tlast,   // done_res
	input  logic                               cfg_we,
	input  logic [bmp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bmp_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bmp_pkg::*;

	cfg_t       cfg_q;
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;
	logic       advance;
	logic       step;
	logic       core_valid;
	res_t       core_res;
	logic       out_valid_q;
	res_t       out_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x          <= 16'd0;
			cfg_q.origin_y          <= 16'd0;
			cfg_q.transparent_color <= TRANSPARENT_OFF;
			cfg_q.screen_width      <= SCREEN_W_RST;
			cfg_q.screen_height     <= SCREEN_H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X:      cfg_q.origin_x          <= cfg_data[15:0];
				CFG_ORIGIN_Y:      cfg_q.origin_y          <= cfg_data[15:0];
				CFG_TRANSPARENT:   cfg_q.transparent_color <= cfg_data;
				CFG_SCREEN_WIDTH:  cfg_q.screen_width      <= cfg_data[14:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height     <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the result register is free.
	assign advance  = !out_valid_q || m_tready;
	assign step     = v_s1 && advance;
	assign s_tready = !v_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			sof_s1  <= s_tuser;
		end
	end

	// Parser and pixel converter.
	bmp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.sof       (sof_s1),
		.cfg       (cfg_q),
		.res_valid (core_valid),
		.res       (core_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_valid) begin
			out_q <= core_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.pixel_color, out_q.pixel_y, out_q.pixel_x};
	assign m_tuser  = {out_q.status, out_q.draw_pixel};
	assign m_tlast  = out_q.done_res;

endmodule

>>> src/bmp_core.sv
// Header parser, pixel converter and coordinate generator for one file byte per step.
module bmp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    data_byte,
	input  logic          sof,
	input  bmp_pkg::cfg_t cfg,
	output logic          res_valid,
	output bmp_pkg::res_t res
);
	import bmp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [7:0]  sig_lo_q, sig_lo_d;
	logic [31:0] offset_q, offset_d;
	logic [31:0] hdr_size_q, hdr_size_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        bottom_up_q, bottom_up_d;
	logic [15:0] planes_q, planes_d;
	logic [7:0]  depth_lo_q, depth_lo_d;
	logic        comp_nz_q, comp_nz_d;
	logic [15:0] row_q, row_d;
	logic [16:0] k_q, k_d;
	logic [14:0] col_q, col_d;
	logic [1:0]  tri_q, tri_d;
	logic [7:0]  blue_q, blue_d;
	logic [7:0]  green_q, green_d;

	// Per-step decisions handed to the output logic.
	logic        ev_done, ev_status, ev_draw;

	// Helper values.
	phase_t      cur_phase;
	logic [31:0] cur_pos;
	logic [5:0]  hp;
	logic [1:0]  lane4;
	logic        lane2;
	logic        offscreen;
	logic        active;
	logic [15:0] h_full;
	logic [31:0] hdr_end_pos;
	logic        hdr_bad;
	logic        img_empty;
	logic [14:0] w;
	logic [16:0] row_bytes;
	logic [16:0] k_inc;
	logic [15:0] row_inc;
	logic [15:0] pix_color;
	logic        transparent_hit;
	logic [15:0] disp_row;

	// Values that do not depend on the sequencing below.
	assign cur_phase   = sof ? PH_HEADER : phase_q;
	assign cur_pos     = sof ? 32'd0 : pos_q;
	assign hp          = cur_pos[5:0];
	assign offscreen   = ($signed(cfg.origin_x) >= $signed({1'b0, cfg.screen_width})) ||
		($signed(cfg.origin_y) >= $signed({1'b0, cfg.screen_height}));
	assign active      = sof || (phase_q == PH_HEADER) || (phase_q == PH_SKIP) ||
		(phase_q == PH_PIXEL);
	assign hdr_end_pos = (hdr_size_q > CORE_HDR_BYTES) ? HDR_END_LONG : HDR_END_SHORT;
	assign hdr_bad     = (planes_q != 16'd1) || comp_nz_q || (offset_q < hdr_end_pos);
	assign img_empty   = (width_q == 16'd0) || width_q[15] || (height_q == 16'd0);
	assign h_full      = {data_byte, height_q[7:0]};
	assign w           = width_q[14:0];
	// Row length rounded up to four bytes: (3w + 3) with the low two bits cleared.
	assign row_bytes   = ({2'b00, w} + {1'b0, w, 1'b0} + 17'd3) & ~17'd3;
	assign k_inc       = k_q + 17'd1;
	assign row_inc     = row_q + 16'd1;
	assign pix_color   = {data_byte[7:3], green_q[7:2], blue_q[7:3]};
	assign transparent_hit = (cfg.transparent_color != TRANSPARENT_OFF) &&
		(pix_color == cfg.transparent_color[15:0]);
	assign disp_row    = bottom_up_q ? (height_q - 16'd1 - row_q) : row_q;

	// Next state of the parser and the pixel counters.
	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		sig_lo_d    = sig_lo_q;
		offset_d    = offset_q;
		hdr_size_d  = hdr_size_q;
		width_d     = width_q;
		height_d    = height_q;
		bottom_up_d = bottom_up_q;
		planes_d    = planes_q;
		depth_lo_d  = depth_lo_q;
		comp_nz_d   = comp_nz_q;
		row_d       = row_q;
		k_d         = k_q;
		col_d       = col_q;
		tri_d       = tri_q;
		blue_d      = blue_q;
		green_d     = green_q;
		ev_done     = 1'b0;
		ev_status   = STATUS_OK;
		ev_draw     = 1'b0;
		lane4       = 2'(hp - POS_OFFSET);
		lane2       = 1'b0;

		if (step && sof) begin
			// A start byte drops whatever image was in progress.
			phase_d     = PH_HEADER;
			pos_d       = 32'd0;
			offset_d    = 32'd0;
			hdr_size_d  = 32'd0;
			width_d     = 16'd0;
			height_d    = 16'd0;
			bottom_up_d = 1'b1;
			planes_d    = 16'd0;
			depth_lo_d  = 8'd0;
			comp_nz_d   = 1'b0;
			row_d       = 16'd0;
			k_d         = 17'd0;
			col_d       = 15'd0;
			tri_d       = 2'd0;
		end

		if (step && sof && offscreen) begin
			phase_d = PH_DONE;
			ev_done = 1'b1;
		end else if (step && active) begin
			pos_d = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;
			if (cur_phase == PH_HEADER) begin
				// Header bytes, little-endian fields.
				if (hp == POS_SIG_LO) begin
					sig_lo_d = data_byte;
				end else if (hp == POS_SIG_HI) begin
					if ({data_byte, sig_lo_q} != BMP_SIGNATURE) begin
						phase_d   = PH_DONE;
						ev_done   = 1'b1;
						ev_status = STATUS_FORMAT;
					end
				end else if (hp inside {[POS_OFFSET:POS_OFFSET + 6'd3]}) begin
					lane4 = 2'(hp - POS_OFFSET);
					offset_d[{lane4, 3'b000} +: 8] = data_byte;
				end else if (hp inside {[POS_HDR_SIZE:POS_HDR_SIZE + 6'd3]}) begin
					lane4 = 2'(hp - POS_HDR_SIZE);
					hdr_size_d[{lane4, 3'b000} +: 8] = data_byte;
				end else if (hp inside {[POS_WIDTH:POS_WIDTH + 6'd1]}) begin
					lane2 = 1'(hp - POS_WIDTH);
					width_d[{lane2, 3'b000} +: 8] = data_byte;
				end else if (hp == POS_HEIGHT) begin
					height_d[7:0] = data_byte;
				end else if (hp == POS_HEIGHT + 6'd1) begin
					// A negative height means top-down rows; keep the magnitude.
					if (h_full[15]) begin
						bottom_up_d = 1'b0;
						height_d    = 16'd0 - h_full;
					end else begin
						height_d = h_full;
					end
				end else if (hp inside {[POS_PLANES:POS_PLANES + 6'd1]}) begin
					lane2 = 1'(hp - POS_PLANES);
					planes_d[{lane2, 3'b000} +: 8] = data_byte;
				end else if (hp == POS_DEPTH) begin
					depth_lo_d = data_byte;
				end else if (hp == POS_DEPTH + 6'd1) begin
					if ({data_byte, depth_lo_q} != BMP_DEPTH_24) begin
						phase_d   = PH_DONE;
						ev_done   = 1'b1;
						ev_status = STATUS_FORMAT;
					end else if (hdr_size_q <= CORE_HDR_BYTES) begin
						if (hdr_bad) begin
							phase_d   = PH_DONE;
							ev_done   = 1'b1;
							ev_status = STATUS_FORMAT;
						end else if (img_empty) begin
							phase_d = PH_DONE;
							ev_done = 1'b1;
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end else if (hp inside {[POS_COMPRESS:POS_COMPRESS + 6'd3]}) begin
					if (data_byte != 8'd0) begin
						comp_nz_d = 1'b1;
					end
				end else if (hp == POS_HDR_LAST) begin
					if (hdr_bad) begin
						phase_d   = PH_DONE;
						ev_done   = 1'b1;
						ev_status = STATUS_FORMAT;
					end else if (img_empty) begin
						phase_d = PH_DONE;
						ev_done = 1'b1;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end else if ((cur_phase == PH_PIXEL) || (pos_q == offset_q)) begin
				// Pixel data: BGR triples, then padding to the row length.
				phase_d = PH_PIXEL;
				if (col_q < w) begin
					case (tri_q)
						2'd0: begin
							blue_d = data_byte;
							tri_d  = 2'd1;
						end
						2'd1: begin
							green_d = data_byte;
							tri_d   = 2'd2;
						end
						2'd2: begin
							ev_draw = !transparent_hit;
							tri_d   = 2'd0;
							col_d   = col_q + 15'd1;
						end
						default: begin
							tri_d = 2'd0;
						end
					endcase
				end
				if (k_inc >= row_bytes) begin
					k_d   = 17'd0;
					col_d = 15'd0;
					tri_d = 2'd0;
					row_d = row_inc;
					if (row_inc >= height_q) begin
						phase_d = PH_DONE;
						ev_done = 1'b1;
					end
				end else begin
					k_d = k_inc;
				end
			end
		end
	end

	// Result item built from this step's decisions.
	always_comb begin
		res_valid       = ev_done || ev_draw;
		res.draw_pixel  = ev_draw;
		res.pixel_x     = ev_draw ? (cfg.origin_x + {1'b0, col_q}) : 16'd0;
		res.pixel_y     = ev_draw ? (cfg.origin_y + disp_row) : 16'd0;
		res.pixel_color = ev_draw ? pix_color : 16'd0;
		res.done_res    = ev_done;
		res.status      = ev_done ? ev_status : STATUS_OK;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= 32'd0;
			offset_q    <= 32'd0;
			hdr_size_q  <= 32'd0;
			width_q     <= 16'd0;
			height_q    <= 16'd0;
			bottom_up_q <= 1'b1;
			planes_q    <= 16'd0;
			depth_lo_q  <= 8'd0;
			comp_nz_q   <= 1'b0;
			row_q       <= 16'd0;
			k_q         <= 17'd0;
			col_q       <= 15'd0;
			tri_q       <= 2'd0;
		end else begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			offset_q    <= offset_d;
			hdr_size_q  <= hdr_size_d;
			width_q     <= width_d;
			height_q    <= height_d;
			bottom_up_q <= bottom_up_d;
			planes_q    <= planes_d;
			depth_lo_q  <= depth_lo_d;
			comp_nz_q   <= comp_nz_d;
			row_q       <= row_d;
			k_q         <= k_d;
			col_q       <= col_d;
			tri_q       <= tri_d;
		end
	end

	// Byte holding registers for the signature and the partial pixel.
	always_ff @(posedge clk) begin
		sig_lo_q <= sig_lo_d;
		blue_q   <= blue_d;
		green_q  <= green_d;
	end

endmodule

>>> test/tb_bmp24_to_rgb565_stream_decoder.sv
// Self-checking testbench for the BMP 24-bit to RGB565 stream decoder.
module tb_bmp24_to_rgb565_stream_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import bmp_pkg::*;

	// Kinds of generated files.
	typedef enum int {
		KIND_GOOD,
		KIND_BAD_SIG,
		KIND_BAD_DEPTH,
		KIND_BAD_PLANES,
		KIND_BAD_COMPR,
		KIND_BAD_OFFSET,
		KIND_EMPTY,
		KIND_HUGE
	} file_kind_t;

	localparam int FILE_KINDS = 8;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_BYTES = 220;
	localparam int REPORT_LIMIT = 100;

	// One byte of a file on its way to the decoder.
	typedef struct {
		logic [7:0] data;
		logic       sof;
	} file_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	file_byte_t byte_q[$];
	res_t       decoded_q[$];
	file_byte_t drv_item;
	int         item_total = 0;
	int         mismatch_count = 0;
	int         src_hold = 0;
	int         sink_hold = 0;
	bit         quiet = 1'b0;

	// Register copies used by the decoder model.
	logic [15:0] reg_origin_x = '0;
	logic [15:0] reg_origin_y = '0;
	logic [16:0] reg_transparent = TRANSPARENT_OFF;
	logic [14:0] reg_screen_w = SCREEN_W_RST;
	logic [14:0] reg_screen_h = SCREEN_H_RST;

	// Decoder model state.
	phase_t      dec_phase = PH_IDLE;
	logic [31:0] dec_pos = '0;
	logic [15:0] dec_sig = '0;
	logic [31:0] dec_offset = '0;
	logic [31:0] dec_hdr_size = '0;
	logic [15:0] dec_width = '0;
	logic [15:0] dec_height = '0;
	logic        dec_bottom_up = 1'b1;
	logic [15:0] dec_planes = '0;
	logic [15:0] dec_depth = '0;
	logic [31:0] dec_compr = '0;
	logic [15:0] dec_row = '0;
	logic [31:0] dec_row_byte = '0;
	logic [15:0] dec_blue_green = '0;
	res_t        next_res;
	bit          next_has;

	bmp24_to_rgb565_stream_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Ends the image with a done result carrying the given status.
	task automatic close_image(input logic st);
		dec_phase = PH_DONE;
		next_res.done_res = 1'b1;
		next_res.status = st;
		next_has = 1'b1;
	endtask

	// Checks the complete header and either ends the image or moves on to the pixel data.
	task automatic finish_header();
		logic [31:0] hdr_end;
		hdr_end = (dec_hdr_size > CORE_HDR_BYTES) ? HDR_END_LONG : HDR_END_SHORT;
		if (dec_planes != 16'd1 || dec_compr != 32'd0 || dec_offset < hdr_end) begin
			close_image(STATUS_FORMAT);
		end else if (dec_width == 16'd0 || dec_width[15] || dec_height == 16'd0) begin
			close_image(STATUS_OK);
		end else begin
			dec_phase = PH_SKIP;
			dec_row = '0;
			dec_row_byte = '0;
		end
	endtask

	// Collects one header byte into its field.
	task automatic header_step(input logic [7:0] fb);
		logic [31:0] p;
		p = dec_pos;
		if (p < 2) begin
			dec_sig = dec_sig | (16'(fb) << (8 * p));
			if (p == 1 && dec_sig != BMP_SIGNATURE)
				close_image(STATUS_FORMAT);
		end else if (p >= 10 && p < 14) begin
			dec_offset = dec_offset | (32'(fb) << (8 * (p - 10)));
		end else if (p >= 14 && p < 18) begin
			dec_hdr_size = dec_hdr_size | (32'(fb) << (8 * (p - 14)));
		end else if (p >= 18 && p < 20) begin
			dec_width = dec_width | (16'(fb) << (8 * (p - 18)));
		end else if (p >= 22 && p < 24) begin
			dec_height = dec_height | (16'(fb) << (8 * (p - 22)));
			if (p == 23 && dec_height[15]) begin
				dec_bottom_up = 1'b0;
				dec_height = 16'd0 - dec_height;
			end
		end else if (p >= 26 && p < 28) begin
			dec_planes = dec_planes | (16'(fb) << (8 * (p - 26)));
		end else if (p >= 28 && p < 30) begin
			dec_depth = dec_depth | (16'(fb) << (8 * (p - 28)));
			if (p == 29) begin
				if (dec_depth != BMP_DEPTH_24)
					close_image(STATUS_FORMAT);
				else if (dec_hdr_size <= CORE_HDR_BYTES)
					finish_header();
			end
		end else if (p >= 30 && p < 34) begin
			dec_compr = dec_compr | (32'(fb) << (8 * (p - 30)));
		end else if (p == 53) begin
			finish_header();
		end
	endtask

	// Assembles BGR triples into RGB565 pixels and walks rows and padding.
	task automatic pixel_step(input logic [7:0] fb);
		int          w;
		int          row_size;
		int          k;
		logic [15:0] color;
		logic [15:0] disp;
		w = int'(dec_width[14:0]);
		row_size = ((24 * w + 31) / 32) * 4;
		k = int'(dec_row_byte);
		if (k < 3 * w) begin
			case (k % 3)
				0: dec_blue_green = {8'h00, fb};
				1: dec_blue_green[15:8] = fb;
				default: begin
					color = {fb[7:3], dec_blue_green[15:10], dec_blue_green[7:3]};
					if (reg_transparent == TRANSPARENT_OFF || color != reg_transparent[15:0]) begin
						disp = dec_bottom_up ? (dec_height - 16'd1 - dec_row) : dec_row;
						next_res.draw_pixel = 1'b1;
						next_res.pixel_x = reg_origin_x + 16'(k / 3);
						next_res.pixel_y = reg_origin_y + disp;
						next_res.pixel_color = color;
						next_has = 1'b1;
					end
				end
			endcase
		end
		k++;
		if (k >= row_size) begin
			k = 0;
			dec_row = dec_row + 16'd1;
			if (dec_row >= dec_height)
				close_image(STATUS_OK);
		end
		dec_row_byte = 32'(k);
	endtask

	// Works out the result, if any, of one accepted file byte.
	task automatic decode_file_byte(input logic [7:0] fb, input logic sof);
		int ox_i;
		int oy_i;
		next_res = '0;
		next_has = 1'b0;
		if (sof) begin
			dec_phase = PH_HEADER;
			dec_pos = '0;
			dec_sig = '0;
			dec_offset = '0;
			dec_hdr_size = '0;
			dec_width = '0;
			dec_height = '0;
			dec_planes = '0;
			dec_depth = '0;
			dec_compr = '0;
			dec_row = '0;
			dec_row_byte = '0;
			dec_blue_green = '0;
			dec_bottom_up = 1'b1;
			ox_i = $signed(reg_origin_x);
			oy_i = $signed(reg_origin_y);
			if (ox_i >= int'(reg_screen_w) || oy_i >= int'(reg_screen_h))
				close_image(STATUS_OK);
		end
		if (dec_phase == PH_HEADER) begin
			header_step(fb);
		end else if (dec_phase == PH_SKIP || dec_phase == PH_PIXEL) begin
			if (dec_phase == PH_SKIP && dec_pos == dec_offset)
				dec_phase = PH_PIXEL;
			if (dec_phase == PH_PIXEL)
				pixel_step(fb);
		end
		if (dec_pos != 32'hFFFF_FFFF)
			dec_pos = dec_pos + 32'd1;
		if (next_has)
			decoded_q.push_back(next_res);
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] seen,
			input logic [15:0] want);
		if (mismatch_count < REPORT_LIMIT)
			$display("%0t: %s mismatch, got %h, want %h", $time, what, seen, want);
		mismatch_count++;
	endtask

	// Compares one result transfer with the oldest decoded result.
	task automatic check_result();
		res_t want;
		if (decoded_q.size() == 0) begin
			report_mismatch("result with none pending", m_tdata[15:0], 16'h0);
		end else begin
			want = decoded_q.pop_front();
			if (m_tuser[0] !== want.draw_pixel)
				report_mismatch("draw_pixel", 16'(m_tuser[0]), 16'(want.draw_pixel));
			if (m_tdata[15:0] !== want.pixel_x)
				report_mismatch("pixel_x", m_tdata[15:0], want.pixel_x);
			if (m_tdata[31:16] !== want.pixel_y)
				report_mismatch("pixel_y", m_tdata[31:16], want.pixel_y);
			if (m_tdata[47:32] !== want.pixel_color)
				report_mismatch("pixel_color", m_tdata[47:32], want.pixel_color);
			if (m_tlast !== want.done_res)
				report_mismatch("done_res", 16'(m_tlast), 16'(want.done_res));
			if (m_tuser[1] !== want.status)
				report_mismatch("status", 16'(m_tuser[1]), 16'(want.status));
		end
	endtask

	// Byte driver: feeds the queue to the input channel with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			src_hold = 0;
		end else begin
			if (s_tvalid && s_tready)
				decode_file_byte(s_tdata, s_tuser);
			if (!s_tvalid || s_tready) begin
				if (src_hold > 0) begin
					s_tvalid <= 1'b0;
					src_hold--;
				end else if (byte_q.size() != 0) begin
					drv_item = byte_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= drv_item.data;
					s_tuser <= drv_item.sof;
					if (!quiet && $urandom_range(0, 5) == 0)
						src_hold = $urandom_range(1, 5);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transfer and stalls in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_hold = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				sink_hold = $urandom_range(0, 4);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic sof);
		file_byte_t fbt;
		fbt.data = b;
		fbt.sof = sof;
		byte_q.push_back(fbt);
		item_total++;
	endtask

	// Appends the low bytes of a little-endian field.
	task automatic push_field(input logic [31:0] v, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			push_byte(v[8 * i +: 8], 1'b0);
	endtask

	// Up to two bytes after the end of an image, which the decoder ignores.
	task automatic push_tail();
		repeat ($urandom_range(0, 2))
			push_byte(8'($urandom), 1'b0);
	endtask

	// Builds one file of the given kind and queues its bytes.
	task automatic gen_bmp_file(input file_kind_t kind);
		logic [31:0] hdr_size;
		logic [31:0] offset;
		logic [31:0] rnd;
		logic [31:0] w;
		logic [15:0] hfield;
		logic [15:0] planes;
		logic [15:0] depth;
		logic [7:0]  b0;
		logic [7:0]  b1;
		int          hdr_end;
		int          rows;
		int          row_size;
		int          total;
		int          stop_at;
		int          k;
		bit          top_down;
		bit          match;
		if (kind == KIND_BAD_SIG) begin
			b0 = 8'($urandom);
			b1 = 8'($urandom);
			if ({b1, b0} == BMP_SIGNATURE)
				b1[$urandom_range(0, 7)] ^= 1'b1;
			push_byte(b0, 1'b1);
			push_byte(b1, 1'b0);
			push_tail();
		end else begin
			push_byte(BMP_SIGNATURE[7:0], 1'b1);
			push_byte(BMP_SIGNATURE[15:8], 1'b0);
			push_field($urandom, 4);
			push_field($urandom, 4);

			// Core header ends at byte 30, longer headers at byte 54.
			if (kind == KIND_BAD_COMPR || $urandom_range(0, 2) != 0) begin
				hdr_end = 54;
				hdr_size = ($urandom_range(0, 3) == 0) ? ($urandom | 32'h10) : 32'd40;
			end else begin
				hdr_end = 30;
				hdr_size = $urandom_range(0, 1) ? 32'd12 : 32'($urandom_range(0, 12));
			end
			offset = hdr_end + $urandom_range(0, 3);
			if (kind == KIND_BAD_OFFSET)
				offset = $urandom_range(0, hdr_end - 1);

			w = $urandom_range(1, 4);
			rows = $urandom_range(1, 3);
			top_down = 1'($urandom);
			if (kind == KIND_HUGE) begin
				case ($urandom_range(0, 2))
					0: w = 32'h7FFF;
					1: begin
						rows = 32768;
						top_down = 1'b1;
					end
					default: begin
						rows = 32767;
						top_down = 1'b0;
					end
				endcase
			end else if (kind == KIND_EMPTY) begin
				case ($urandom_range(0, 2))
					0: w = 0;
					1: w = 32'h8000 | $urandom_range(0, 32767);
					default: rows = 0;
				endcase
			end
			hfield = top_down ? (16'd0 - 16'(rows)) : 16'(rows);

			planes = 16'd1;
			if (kind == KIND_BAD_PLANES) begin
				case ($urandom_range(0, 2))
					0: planes = 16'd0;
					1: planes = 16'h0101;
					default: planes = 16'($urandom_range(2, 65535));
				endcase
			end
			depth = BMP_DEPTH_24;
			if (kind == KIND_BAD_DEPTH) begin
				case ($urandom_range(0, 2))
					0: depth = BMP_DEPTH_24 | 16'h0100;
					1: depth = 16'd32;
					default: depth = 16'($urandom_range(25, 65535));
				endcase
			end

			// Upper halves of width and height are random; only the low 16 bits count.
			push_field(offset, 4);
			push_field(hdr_size, 4);
			rnd = $urandom;
			push_field({rnd[31:16], w[15:0]}, 4);
			rnd = $urandom;
			push_field({rnd[31:16], hfield}, 4);
			push_field(32'(planes), 2);
			push_field(32'(depth), 2);
			if (kind == KIND_BAD_DEPTH) begin
				push_tail();
				return;
			end
			if (hdr_end == 54) begin
				push_field((kind == KIND_BAD_COMPR) ? (32'h1 << $urandom_range(0, 31)) : 32'h0, 4);
				repeat (20)
					push_byte(8'($urandom), 1'b0);
			end
			if (kind != KIND_GOOD && kind != KIND_HUGE) begin
				push_tail();
				return;
			end

			// Gap up to the pixel data.
			repeat (int'(offset) - hdr_end)
				push_byte(8'($urandom), 1'b0);

			// Pixel rows with padding; some pixels hit the transparent color.
			row_size = ((24 * int'(w[14:0]) + 31) / 32) * 4;
			total = row_size * rows;
			stop_at = total;
			if (kind == KIND_HUGE)
				stop_at = $urandom_range(6, 30);
			else if ($urandom_range(0, 7) == 0)
				stop_at = $urandom_range(0, total - 1);
			match = 1'b0;
			for (int n = 0; n < stop_at; n++) begin
				k = n % row_size;
				rnd = $urandom;
				if (k < 3 * int'(w[14:0])) begin
					if (k % 3 == 0)
						match = ($urandom_range(0, 2) == 0);
					if (!match)
						push_byte(rnd[7:0], 1'b0);
					else if (k % 3 == 0)
						push_byte({reg_transparent[4:0], rnd[2:0]}, 1'b0);
					else if (k % 3 == 1)
						push_byte({reg_transparent[10:5], rnd[1:0]}, 1'b0);
					else
						push_byte({reg_transparent[15:11], rnd[2:0]}, 1'b0);
				end else begin
					push_byte(rnd[7:0], 1'b0);
				end
			end
			if (stop_at == total)
				push_tail();
		end
	endtask

	// Waits until every byte is taken and every result has come out.
	task automatic wait_idle();
		while (byte_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Writes all registers and mirrors them into the model.
	task automatic set_config(input logic [16:0] ox, input logic [16:0] oy,
			input logic [16:0] tc, input logic [16:0] sw, input logic [16:0] sh);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_TRANSPARENT, tc);
		write_reg(CFG_SCREEN_WIDTH, sw);
		write_reg(CFG_SCREEN_HEIGHT, sh);
		reg_origin_x = ox[15:0];
		reg_origin_y = oy[15:0];
		reg_transparent = tc;
		reg_screen_w = sw[14:0];
		reg_screen_h = sh[14:0];
	endtask

	// Stimulus: directed bytes, then phases of random files under several settings.
	initial begin
		int          start_total;
		int          k;
		logic [31:0] r0;
		logic [31:0] r1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Bytes before any start, a bad signature, bytes after done,
		// a swapped signature and a restart in the middle of a header.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h42, 1'b1);
		push_byte(8'h4C, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h4D, 1'b1);
		push_byte(8'h42, 1'b0);
		push_byte(8'h42, 1'b1);
		push_byte(8'h4D, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		wait_idle();

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			r0 = $urandom_range(0, 80) - 40;
			r1 = $urandom_range(0, 80) - 40;
			case (ph)
				0: set_config(17'h0, 17'h0, TRANSPARENT_OFF, 17'(SCREEN_W_RST),
					17'(SCREEN_H_RST));
				// Most negative origin with an empty screen is still on screen.
				1: set_config(17'h08000, 17'h08000, 17'h0, 17'h0, 17'h0);
				// Origin near the top of the range: coordinates wrap.
				2: set_config(17'h07FFE, 17'h07FFE, 17'h0FFFF, 17'h07FFF, 17'h07FFF);
				// Origin exactly at the screen edge: every image ends at once.
				3: set_config(17'h07FFF, 17'h0, 17'h0F800, 17'h07FFF, 17'd240);
				4: set_config(r0[16:0], r1[16:0], 17'($urandom_range(0, 17'h1FFFF)),
					17'($urandom_range(0, 60)), 17'($urandom_range(0, 60)));
				default: set_config(17'($urandom_range(0, 20)), 17'($urandom_range(0, 20)),
					17'h10000 | 17'($urandom_range(0, 16'hFFFE)), 17'd320, 17'd240);
			endcase
			@(negedge clk);
			if (ph == PHASE_COUNT - 1)
				quiet = 1'b1;
			start_total = item_total;
			k = 0;
			while (item_total - start_total < PHASE_BYTES) begin
				if (k < FILE_KINDS)
					gen_bmp_file(file_kind_t'((k + ph) % FILE_KINDS));
				else if ($urandom_range(0, 9) < 5)
					gen_bmp_file(KIND_GOOD);
				else
					gen_bmp_file(file_kind_t'($urandom_range(1, FILE_KINDS - 1)));
				k++;
			end
			wait_idle();
		end

		if (mismatch_count == 0 && decoded_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Run limit.
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
